// ===== rtl/cxd_pkg.sv =====
// Shared types, constants and decode helpers for the IR frame decoder.
`default_nettype none
package cxd_pkg;

	// Pulse timing
	localparam int NOM_CNT = 4;
	localparam int NOM_W = 13;
	localparam int TOL_W = 7;
	localparam int PCT_W = 8;
	localparam int PROD_W = NOM_W + PCT_W;
	localparam int DUR_W = 16;
	localparam int SCALE_W = 24;

	localparam int NOM_HDR_MARK = 0;
	localparam int NOM_HDR_SPACE = 1;
	localparam int NOM_BIT_MARK = 2;  // also the zero-bit space
	localparam int NOM_ONE_SPACE = 3;

	localparam logic [NOM_W-1:0] NOMINAL_US [NOM_CNT] = '{
		13'd4692, 13'd4416, 13'd552, 13'd1656
	};

	localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;
	localparam logic [SCALE_W-1:0] PCT_ROUND = 24'd99;
	localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

	// Frame geometry
	localparam int FRAME_BITS = 48;
	localparam int BIT_CNT_W = 6;
	localparam int WORD_W = 24;
	localparam int QUEUE_DEPTH = 2;

	// Known frames and words
	localparam logic [FRAME_BITS-1:0] ECO_ON_FRAME = 48'hB54AF50A8240;
	localparam logic [FRAME_BITS-1:0] ECO_OFF_FRAME = 48'hB54AF50A8340;
	localparam logic [WORD_W-1:0] OFF_WORD = 24'hB27BE0;
	localparam logic [7:0] STATE_PREFIX = 8'hB2;
	localparam logic [3:0] FAN_ONLY_NIBBLE = 4'hE;
	localparam int TOGGLE_CNT = 5;
	localparam logic [WORD_W-1:0] TOGGLE_WORDS [TOGGLE_CNT] = '{
		24'hB2E003, 24'hB5F5A2, 24'hB5F5A5, 24'hB5F5AA, 24'hB20FE0
	};

	// Result codes
	localparam logic [2:0] KIND_REJECT = 3'd0;
	localparam logic [2:0] KIND_ECO = 3'd1;
	localparam logic [2:0] KIND_OFF = 3'd2;
	localparam logic [2:0] KIND_TOGGLE = 3'd3;
	localparam logic [2:0] KIND_STATE = 3'd4;

	localparam logic [2:0] MODE_OFF = 3'd0;
	localparam logic [2:0] MODE_FAN_ONLY = 3'd4;
	localparam logic [1:0] MBITS_INVALID = 2'd3;
	localparam logic [1:0] MBITS_FAN = 2'd1;
	localparam logic [4:0] TEMP_RESET = 5'd24;

	localparam logic [1:0] FAN_AUTO = 2'd0;
	localparam logic [1:0] FAN_LOW = 2'd1;
	localparam logic [1:0] FAN_MED = 2'd2;
	localparam logic [1:0] FAN_HIGH = 2'd3;
	localparam logic [2:0] FAN_CODE_LOW = 3'd4;
	localparam logic [2:0] FAN_CODE_MED = 3'd2;
	localparam logic [2:0] FAN_CODE_HIGH = 3'd1;

	typedef enum logic [2:0] {
		PH_HDR_MARK,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic is_mark;
		logic [DUR_W-1:0] duration_us;
		logic capture_start;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic [2:0] frame_kind;
		logic [2:0] toggle_id;
		logic [WORD_W-1:0] raw_word;
		logic [2:0] cur_mode;
		logic [4:0] cur_temp_c;
		logic [1:0] cur_fan;
		logic cur_eco;
	} result_t;

	// One decision from the front end: a full frame or an early reject
	typedef struct packed {
		logic complete;
		logic [FRAME_BITS-1:0] frame;
	} q_entry_t;

	// Scaled window limits: nominal * (100 -/+ tol)
	typedef struct packed {
		logic [NOM_CNT-1:0][PROD_W-1:0] lo;
		logic [NOM_CNT-1:0][PROD_W-1:0] hi;
	} bounds_t;

	typedef struct packed {
		logic valid;
		logic [4:0] temp;
	} temp_dec_t;

	typedef struct packed {
		logic hit;
		logic [2:0] id;
	} toggle_dec_t;

	function automatic bounds_t calc_bounds(input logic [TOL_W-1:0] tol);
		bounds_t b;
		logic [PCT_W-1:0] up;
		logic [PCT_W-1:0] dn;
		up = PCT_FULL + PCT_W'(tol);
		dn = PCT_FULL - PCT_W'(tol);
		for (int k = 0; k < NOM_CNT; k++) begin
			b.hi[k] = PROD_W'(NOMINAL_US[k]) * PROD_W'(up);
			b.lo[k] = (PCT_W'(tol) >= PCT_FULL) ? '0 : PROD_W'(NOMINAL_US[k]) * PROD_W'(dn);
		end
		return b;
	endfunction

	function automatic temp_dec_t decode_temp(input logic [3:0] nib);
		temp_dec_t r;
		r.valid = 1'b1;
		unique case (nib)
			4'h0: r.temp = 5'd17;
			4'h1: r.temp = 5'd18;
			4'h3: r.temp = 5'd19;
			4'h2: r.temp = 5'd20;
			4'h6: r.temp = 5'd21;
			4'h7: r.temp = 5'd22;
			4'h5: r.temp = 5'd23;
			4'h4: r.temp = 5'd24;
			4'hC: r.temp = 5'd25;
			4'hD: r.temp = 5'd26;
			4'h9: r.temp = 5'd27;
			4'h8: r.temp = 5'd28;
			4'hA: r.temp = 5'd29;
			4'hB: r.temp = 5'd30;
			default: begin
				r.valid = 1'b0;
				r.temp = TEMP_RESET;
			end
		endcase
		return r;
	endfunction

	function automatic logic [1:0] decode_fan(input logic [2:0] code);
		logic [1:0] f;
		unique case (code)
			FAN_CODE_LOW: f = FAN_LOW;
			FAN_CODE_MED: f = FAN_MED;
			FAN_CODE_HIGH: f = FAN_HIGH;
			default: f = FAN_AUTO;
		endcase
		return f;
	endfunction

	function automatic toggle_dec_t match_toggle(input logic [WORD_W-1:0] word);
		toggle_dec_t r;
		r.hit = 1'b0;
		r.id = '0;
		for (int i = TOGGLE_CNT - 1; i >= 0; i--) begin
			if (word == TOGGLE_WORDS[i]) begin
				r.hit = 1'b1;
				r.id = 3'(i);
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cxd_front.sv =====
// Front end: pulse window matching, frame parser state machine, tolerance limits.
`default_nettype none
module cxd_front (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	input  wire logic [cxd_pkg::TOL_W-1:0]         cfg_data,
	input  wire logic                              in_valid,
	input  wire cxd_pkg::in_item_t                 in_data,
	input  wire logic                              q_ready,
	output logic                                   push,
	output cxd_pkg::q_entry_t                      push_data
);
	import cxd_pkg::*;

	bounds_t bounds_q;
	phase_t phase_q, phase_n, phase_eff;
	logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_n, bit_cnt_eff, bit_cnt_inc;
	logic [FRAME_BITS-1:0] frame_q, frame_n, frame_eff;
	logic [SCALE_W-1:0] dur_scaled;
	logic [NOM_CNT-1:0] hit;
	logic take;

	assign take = in_valid && q_ready;

	// Limits are recomputed at the config write so the next pulse sees them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounds_q <= calc_bounds(TOL_RESET);
		end else if (cfg_valid) begin
			bounds_q <= calc_bounds(cfg_data);
		end
	end

	// floor(a/100) <= d  <=>  a <= 100d + 99 ;  d <= floor(b/100)  <=>  100d <= b
	assign dur_scaled = SCALE_W'(in_data.duration_us) * SCALE_W'(PCT_FULL);

	always_comb begin
		for (int k = 0; k < NOM_CNT; k++) begin
			hit[k] = (SCALE_W'(bounds_q.lo[k]) <= dur_scaled + PCT_ROUND) &&
				(dur_scaled <= SCALE_W'(bounds_q.hi[k]));
		end
	end

	assign phase_eff = in_data.capture_start ? PH_HDR_MARK : phase_q;
	assign bit_cnt_eff = in_data.capture_start ? '0 : bit_cnt_q;
	assign frame_eff = in_data.capture_start ? '0 : frame_q;
	assign bit_cnt_inc = bit_cnt_eff + BIT_CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR_MARK;
			bit_cnt_q <= '0;
			frame_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			bit_cnt_q <= bit_cnt_n;
			frame_q <= frame_n;
		end
	end

	always_comb begin
		logic fail;
		fail = 1'b0;
		phase_n = phase_eff;
		bit_cnt_n = bit_cnt_eff;
		frame_n = frame_eff;
		push = 1'b0;
		push_data.complete = 1'b0;
		push_data.frame = '0;
		unique case (phase_eff)
			PH_HDR_MARK: begin
				if (in_data.is_mark && hit[NOM_HDR_MARK]) phase_n = PH_HDR_SPACE;
				else fail = 1'b1;
			end
			PH_HDR_SPACE: begin
				if (!in_data.is_mark && hit[NOM_HDR_SPACE]) phase_n = PH_BIT_MARK;
				else fail = 1'b1;
			end
			PH_BIT_MARK: begin
				if (in_data.is_mark && hit[NOM_BIT_MARK]) phase_n = PH_BIT_SPACE;
				else fail = 1'b1;
			end
			PH_BIT_SPACE: begin
				if (!in_data.is_mark && (hit[NOM_ONE_SPACE] || hit[NOM_BIT_MARK])) begin
					// a space inside both windows reads as a one
					frame_n = {frame_eff[FRAME_BITS-2:0], hit[NOM_ONE_SPACE]};
					bit_cnt_n = bit_cnt_inc;
					if (bit_cnt_inc >= BIT_CNT_W'(FRAME_BITS)) begin
						phase_n = PH_DONE;
						push = take;
						push_data.complete = 1'b1;
						push_data.frame = frame_n;
					end else begin
						phase_n = PH_BIT_MARK;
					end
				end else begin
					fail = 1'b1;
				end
			end
			PH_DONE: begin
				phase_n = PH_DONE;
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase
		if (fail) begin
			phase_n = PH_DONE;
			push = take;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cxd_queue.sv =====
// Short first-in first-out queue of decisions between front and back ends.
`default_nettype none
module cxd_queue #(
	parameter int DEPTH = cxd_pkg::QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire cxd_pkg::q_entry_t    push_data,
	output logic                      push_ready,
	input  wire logic                 pop,
	output logic                      pop_valid,
	output cxd_pkg::q_entry_t         pop_data
);
	import cxd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_entry_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = slot_q[rd_ptr_q];
	assign do_push = push && push_ready;
	assign do_pop = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cxd_back.sv =====
// Back end: frame classification, tracked settings and the output register.
`default_nettype none
module cxd_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	input  wire cxd_pkg::q_entry_t    q_data,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output cxd_pkg::result_t          out_data
);
	import cxd_pkg::*;

	logic [2:0] mode_q, mode_n;
	logic [4:0] temp_q, temp_n;
	logic [1:0] fan_q, fan_n;
	logic eco_q, eco_n;
	logic out_valid_q;
	result_t out_data_q, res;

	logic [7:0] b0, b1, b2, b3, b4, b5;
	logic [WORD_W-1:0] word;
	logic comp_ok;
	logic [1:0] mbits;
	logic [3:0] tcode;
	temp_dec_t tdec;
	toggle_dec_t tog;

	assign pop = q_valid && (!out_valid_q || out_ready);

	assign {b0, b1, b2, b3, b4, b5} = q_data.frame;
	assign word = {b0, b2, b4};
	assign comp_ok = (b1 == ~b0) && (b3 == ~b2) && (b5 == ~b4);
	assign mbits = b4[3:2];
	assign tcode = b4[7:4];
	assign tdec = decode_temp(tcode);
	assign tog = match_toggle(word);

	always_comb begin
		mode_n = mode_q;
		temp_n = temp_q;
		fan_n = fan_q;
		eco_n = eco_q;
		res.accepted = 1'b0;
		res.frame_kind = KIND_REJECT;
		res.toggle_id = '0;
		res.raw_word = q_data.complete ? word : '0;
		if (q_data.complete) begin
			if (q_data.frame == ECO_ON_FRAME || q_data.frame == ECO_OFF_FRAME) begin
				eco_n = (q_data.frame == ECO_ON_FRAME);
				res.accepted = 1'b1;
				res.frame_kind = KIND_ECO;
			end else if (!comp_ok) begin
				res.frame_kind = KIND_REJECT;
			end else if (word == OFF_WORD) begin
				mode_n = MODE_OFF;
				res.accepted = 1'b1;
				res.frame_kind = KIND_OFF;
			end else if (tog.hit) begin
				res.accepted = 1'b1;
				res.frame_kind = KIND_TOGGLE;
				res.toggle_id = tog.id;
			end else if (b0 != STATE_PREFIX) begin
				res.frame_kind = KIND_REJECT;
			end else if (mbits == MBITS_FAN && tcode == FAN_ONLY_NIBBLE) begin
				mode_n = MODE_FAN_ONLY;
				fan_n = decode_fan(b2[7:5]);
				res.accepted = 1'b1;
				res.frame_kind = KIND_STATE;
			end else if (mbits != MBITS_INVALID) begin
				mode_n = 3'(mbits) + 3'd1;
				if (tdec.valid) temp_n = tdec.temp;
				fan_n = decode_fan(b2[7:5]);
				res.accepted = 1'b1;
				res.frame_kind = KIND_STATE;
			end
		end
		res.cur_mode = mode_n;
		res.cur_temp_c = temp_n;
		res.cur_fan = fan_n;
		res.cur_eco = eco_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			temp_q <= TEMP_RESET;
			fan_q <= FAN_AUTO;
			eco_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q <= mode_n;
				temp_q <= temp_n;
				fan_q <= fan_n;
				eco_q <= eco_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule
`default_nettype wire

// ===== rtl/coolix_ir_frame_decoder.sv =====
// Top level of the IR frame decoder: front end, decision queue, back end.
// A result reaches out_valid by way of the queue and then the output register, both registered;
// it waits in the queue while out_ready is low and the output register still holds a result.
// Throughput: one pulse per cycle while in_ready is high; at most one result per pulse.
// A stalled output holds one result and the queue holds QUEUE_DEPTH more before in_ready drops.
// Reset (arst_n low, asynchronous): parser waits for a header mark, tolerance 25 percent,
// tracked mode off, 24 C, fan auto, eco off; queue and output register empty.
`default_nettype none
module coolix_ir_frame_decoder #(
	parameter int QUEUE_DEPTH = cxd_pkg::QUEUE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration: tolerance in percent
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cxd_pkg::TOL_W-1:0]     cfg_data,
	// pulse input
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire cxd_pkg::in_item_t             in_data,
	// decision output
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output cxd_pkg::result_t                   out_data
);
	import cxd_pkg::*;

	logic q_push, q_push_ready, q_pop, q_pop_valid;
	q_entry_t q_push_data, q_pop_data;

	// The config register is a plain write; always taken.
	assign cfg_ready = 1'b1;

	// Pulses flow whenever the queue has room, so the front end never waits
	// on the output side unless a full queue of decisions is backed up.
	assign in_ready = q_push_ready;

	// Front end: each pulse is window-checked against the four nominal lengths
	// (limits precomputed from the tolerance at config time) and advances the
	// header/bit parser. A mismatch or the 48th bit yields one queue transaction.
	cxd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.q_ready   (q_push_ready),
		.push      (q_push),
		.push_data (q_push_data)
	);

	cxd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.push_ready (q_push_ready),
		.pop        (q_pop),
		.pop_valid  (q_pop_valid),
		.pop_data   (q_pop_data)
	);

	// Back end: classifies a complete frame (eco, off, toggle, state word or
	// reject), updates the tracked settings and loads the output register.
	cxd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_pop_valid),
		.q_data    (q_pop_data),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// An accepted result never carries the reject code, and a rejected one always does.
	a_accept_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.accepted == (out_data.frame_kind != KIND_REJECT)))
		else $error("accepted flag and frame kind disagree");

	// Tracked temperature only ever takes values from the code table.
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.cur_temp_c >= 5'd17 && out_data.cur_temp_c <= 5'd30))
		else $error("tracked temperature out of range");

	// A toggle id is only reported for toggle words.
	a_toggle_id: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.frame_kind != KIND_TOGGLE) |-> (out_data.toggle_id == 3'd0))
		else $error("toggle id set on a non-toggle result");

	// A result loaded into the output register comes from a queued decision.
	a_out_from_queue: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(q_pop_valid))
		else $error("output became valid with an empty queue");

endmodule
`default_nettype wire

// ===== bench/ir_decode_checker.sv =====
// Checker for the IR frame decoder: tracks the tolerance, predicts each decision, compares.
module ir_decode_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cfg_valid,
	input wire logic                      cfg_ready,
	input wire logic [cxd_pkg::TOL_W-1:0] cfg_data,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire cxd_pkg::in_item_t         in_data,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire cxd_pkg::result_t          out_data,
	output int                            errors,
	output int                            pending,
	output int                            checked
);
	import cxd_pkg::*;

	localparam logic [2:0] NO_TOGGLE = 3'd0;
	localparam logic [3:0] TEMP_CODES [14] = '{
		4'h0, 4'h1, 4'h3, 4'h2, 4'h6, 4'h7, 4'h5, 4'h4, 4'hC, 4'hD, 4'h9, 4'h8, 4'hA, 4'hB
	};

	logic [TOL_W-1:0] tol;
	phase_t ph;
	int unsigned nbits;
	logic [FRAME_BITS-1:0] shreg;
	logic [2:0] mode;
	logic [4:0] temp;
	logic [1:0] fan;
	logic eco;
	result_t decisions_due [$];
	int fail_n = 0;
	int checked_n = 0;
	result_t want;
	result_t got_r;
	bit got;

	function automatic bit fits(input logic [DUR_W-1:0] dur, input logic [NOM_W-1:0] nom);
		int unsigned lo, hi;
		hi = nom * (100 + tol) / 100;
		lo = (tol >= 100) ? 0 : nom * (100 - tol) / 100;
		return dur >= lo && dur <= hi;
	endfunction

	function automatic result_t snapshot(input logic acc, input logic [2:0] kind,
			input logic [2:0] tid, input logic [WORD_W-1:0] word);
		result_t r;
		r.accepted = acc;
		r.frame_kind = kind;
		r.toggle_id = tid;
		r.raw_word = word;
		r.cur_mode = mode;
		r.cur_temp_c = temp;
		r.cur_fan = fan;
		r.cur_eco = eco;
		return r;
	endfunction

	task automatic classify_frame(output result_t r);
		logic [7:0] b [6];
		logic [WORD_W-1:0] word;
		logic [2:0] fcode;
		logic [3:0] tcode;
		logic [1:0] mb;
		int hit;
		for (int i = 0; i < 6; i++)
			b[i] = shreg[47 - 8 * i -: 8];
		word = {b[0], b[2], b[4]};
		fcode = b[2][7:5];
		tcode = b[4][7:4];
		mb = b[4][3:2];
		hit = -1;
		for (int i = 0; i < TOGGLE_CNT; i++)
			if (hit < 0 && word == TOGGLE_WORDS[i])
				hit = i;
		if (shreg == ECO_ON_FRAME || shreg == ECO_OFF_FRAME) begin
			eco = (shreg == ECO_ON_FRAME);
			r = snapshot(1'b1, KIND_ECO, NO_TOGGLE, word);
		end else if (b[1] != ~b[0] || b[3] != ~b[2] || b[5] != ~b[4]) begin
			r = snapshot(1'b0, KIND_REJECT, NO_TOGGLE, word);
		end else if (word == OFF_WORD) begin
			mode = MODE_OFF;
			r = snapshot(1'b1, KIND_OFF, NO_TOGGLE, word);
		end else if (hit >= 0) begin
			r = snapshot(1'b1, KIND_TOGGLE, 3'(hit), word);
		end else if (b[0] != STATE_PREFIX || mb == MBITS_INVALID) begin
			r = snapshot(1'b0, KIND_REJECT, NO_TOGGLE, word);
		end else begin
			if (mb == MBITS_FAN && tcode == FAN_ONLY_NIBBLE) begin
				mode = MODE_FAN_ONLY;
			end else begin
				mode = 3'(mb) + 3'd1;
				// unknown nibble keeps the old temperature
				for (int i = 0; i < 14; i++)
					if (TEMP_CODES[i] == tcode)
						temp = 5'(17 + i);
			end
			case (fcode)
				FAN_CODE_LOW: fan = FAN_LOW;
				FAN_CODE_MED: fan = FAN_MED;
				FAN_CODE_HIGH: fan = FAN_HIGH;
				default: fan = FAN_AUTO;
			endcase
			r = snapshot(1'b1, KIND_STATE, NO_TOGGLE, word);
		end
	endtask

	task automatic track_pulse(input in_item_t p, output bit emit, output result_t r);
		bit ok;
		logic [DUR_W-1:0] d;
		emit = 1'b0;
		r = '0;
		ok = 1'b0;
		d = p.duration_us;
		if (p.capture_start) begin
			ph = PH_HDR_MARK;
			nbits = 0;
			shreg = '0;
		end
		case (ph)
			PH_HDR_MARK: ok = p.is_mark && fits(d, NOMINAL_US[NOM_HDR_MARK]);
			PH_HDR_SPACE: ok = !p.is_mark && fits(d, NOMINAL_US[NOM_HDR_SPACE]);
			PH_BIT_MARK: ok = p.is_mark && fits(d, NOMINAL_US[NOM_BIT_MARK]);
			PH_BIT_SPACE: ok = !p.is_mark && (fits(d, NOMINAL_US[NOM_ONE_SPACE])
					|| fits(d, NOMINAL_US[NOM_BIT_MARK]));
			default: ok = 1'b0;
		endcase
		if (ph == PH_DONE) begin
			// decision already made for this capture
		end else if (!ok) begin
			ph = PH_DONE;
			emit = 1'b1;
			r = snapshot(1'b0, KIND_REJECT, NO_TOGGLE, '0);
		end else begin
			case (ph)
				PH_HDR_MARK: ph = PH_HDR_SPACE;
				PH_HDR_SPACE: ph = PH_BIT_MARK;
				PH_BIT_MARK: ph = PH_BIT_SPACE;
				default: begin
					// overlap of both windows reads as a one
					shreg = {shreg[FRAME_BITS-2:0], fits(d, NOMINAL_US[NOM_ONE_SPACE])};
					nbits++;
					if (nbits >= FRAME_BITS) begin
						ph = PH_DONE;
						emit = 1'b1;
						classify_frame(r);
					end else begin
						ph = PH_BIT_MARK;
					end
				end
			endcase
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fail_n++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol = TOL_RESET;
			ph = PH_HDR_MARK;
			nbits = 0;
			shreg = '0;
			mode = MODE_OFF;
			temp = TEMP_RESET;
			fan = FAN_AUTO;
			eco = 1'b0;
			decisions_due.delete();
			errors <= fail_n;
			pending <= 0;
			checked <= checked_n;
		end else begin
			if (cfg_valid && cfg_ready)
				tol = cfg_data;
			if (in_valid && in_ready) begin
				track_pulse(in_data, got, got_r);
				if (got)
					decisions_due.push_back(got_r);
			end
			if (out_valid && out_ready) begin
				if (decisions_due.size() == 0) begin
					$error("result with none expected: kind %0d word %0h",
						out_data.frame_kind, out_data.raw_word);
					fail_n++;
				end else begin
					want = decisions_due.pop_front();
					check_field("accepted", 32'(want.accepted), 32'(out_data.accepted));
					check_field("frame_kind", 32'(want.frame_kind),
						32'(out_data.frame_kind));
					check_field("toggle_id", 32'(want.toggle_id), 32'(out_data.toggle_id));
					check_field("raw_word", 32'(want.raw_word), 32'(out_data.raw_word));
					check_field("cur_mode", 32'(want.cur_mode), 32'(out_data.cur_mode));
					check_field("cur_temp_c", 32'(want.cur_temp_c),
						32'(out_data.cur_temp_c));
					check_field("cur_fan", 32'(want.cur_fan), 32'(out_data.cur_fan));
					check_field("cur_eco", 32'(want.cur_eco), 32'(out_data.cur_eco));
					checked_n++;
				end
			end
			errors <= fail_n;
			pending <= decisions_due.size();
			checked <= checked_n;
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Testbench top for the IR frame decoder: clock, reset, pulse stimulus, sink stalls, verdict.
module testbench;
	import cxd_pkg::*;

	// generous bound for the watchdog
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 210;
	localparam int PHASE_FRAMES = 2;
	localparam int PULSES_PER_FRAME = 2 + 2 * FRAME_BITS;
	localparam int unsigned HDR_MARK_NOM = 32'(NOMINAL_US[NOM_HDR_MARK]);
	localparam int unsigned HDR_SPACE_NOM = 32'(NOMINAL_US[NOM_HDR_SPACE]);
	localparam int unsigned BIT_MARK_NOM = 32'(NOMINAL_US[NOM_BIT_MARK]);
	localparam int unsigned ONE_SPACE_NOM = 32'(NOMINAL_US[NOM_ONE_SPACE]);

	// Opening pulses at the reset tolerance of 25 percent: {is_mark, duration, capture_start}.
	localparam logic [17:0] OPENING [24] = '{
		// pulses before any capture start are still parsed
		{1'b1, 16'd4692, 1'b0}, {1'b0, 16'd4416, 1'b0}, {1'b1, 16'd552, 1'b0},
		{1'b0, 16'd0, 1'b0},                            // zero-length space: reject
		{1'b1, 16'd65535, 1'b0}, {1'b0, 16'd65535, 1'b0}, // ignored after the decision
		{1'b0, 16'd4416, 1'b1},                         // space where header mark belongs
		{1'b1, 16'd65535, 1'b1},                        // saturated header mark
		// window edges, both bit values
		{1'b1, 16'd5865, 1'b1}, {1'b0, 16'd3312, 1'b0}, {1'b1, 16'd690, 1'b0},
		{1'b0, 16'd1242, 1'b0}, {1'b1, 16'd414, 1'b0}, {1'b0, 16'd690, 1'b0},
		// restart mid-frame: the old capture is dropped silently
		{1'b1, 16'd4692, 1'b1}, {1'b0, 16'd5520, 1'b0}, {1'b1, 16'd552, 1'b0},
		{1'b0, 16'd2070, 1'b0},
		{1'b1, 16'd691, 1'b0},                          // bit mark just too long
		{1'b1, 16'd3518, 1'b1},                         // header mark just too short
		// space between the zero and one windows
		{1'b1, 16'd4692, 1'b1}, {1'b0, 16'd4416, 1'b0}, {1'b1, 16'd552, 1'b0},
		{1'b0, 16'd691, 1'b0}
	};

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [TOL_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	result_t out_data;
	int errors;
	int pending;
	int checked;

	// stimulus bookkeeping
	int unsigned tol_now;
	int burst_left;
	int n_items;
	int n_captures;
	int n_frames;
	int n_settings;
	int cycles;

	coolix_ir_frame_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	ir_decode_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Window edge for a nominal length at the tolerance now programmed.
	function automatic int unsigned win_edge(input int unsigned nom, input bit upper);
		if (upper)
			return nom * (100 + tol_now) / 100;
		return (tol_now >= 100) ? 0 : nom * (100 - tol_now) / 100;
	endfunction

	// Random length inside the window, or outside the span from nom_lo's
	// lower edge to nom_hi's upper edge.
	function automatic logic [15:0] pulse_len(input int unsigned nom_lo,
			input int unsigned nom_hi, input bit fit);
		int unsigned lo, hi;
		lo = win_edge(nom_lo, 1'b0);
		hi = win_edge(nom_hi, 1'b1);
		if (fit)
			return 16'($urandom_range(hi, lo));
		if (lo > 0 && $urandom_range(0, 1) == 1)
			return 16'($urandom_range(lo - 1, 0));
		return 16'($urandom_range(65535, hi + 1));
	endfunction

	// One pulse transaction. The sender runs in bursts; between bursts valid
	// drops for a random gap. Valid is raised without looking at ready.
	task automatic send_pulse(input logic mark, input logic [15:0] dur, input logic start);
		in_item_t p;
		int gap;
		p.is_mark = mark;
		p.duration_us = dur;
		p.capture_start = start;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			// mostly short bursts, now and then a long stretch with no idling
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 12);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= p;
		do @(posedge clk); while (!in_ready);
		burst_left--;
		n_items++;
	endtask

	// First 'upto' pulses of a well-timed capture carrying 'bits', MSB first.
	task automatic send_frame(input logic [FRAME_BITS-1:0] bits, input int upto);
		for (int k = 0; k < upto; k++) begin
			if (k == 0)
				send_pulse(1'b1, pulse_len(HDR_MARK_NOM, HDR_MARK_NOM, 1'b1), 1'b1);
			else if (k == 1)
				send_pulse(1'b0, pulse_len(HDR_SPACE_NOM, HDR_SPACE_NOM, 1'b1), 1'b0);
			else if (k % 2 == 0)
				send_pulse(1'b1, pulse_len(BIT_MARK_NOM, BIT_MARK_NOM, 1'b1), 1'b0);
			else if (bits[47 - (k - 3) / 2])
				send_pulse(1'b0, pulse_len(ONE_SPACE_NOM, ONE_SPACE_NOM, 1'b1), 1'b0);
			else
				send_pulse(1'b0, pulse_len(BIT_MARK_NOM, BIT_MARK_NOM, 1'b1), 1'b0);
		end
	endtask

	// A pulse that breaks the capture at slot k: wrong kind or out of window.
	task automatic send_bad(input int k);
		bit want_mark;
		int unsigned nom_lo, nom_hi;
		want_mark = (k == 0) || (k >= 2 && k % 2 == 0);
		if (k == 0) begin
			nom_lo = HDR_MARK_NOM;
			nom_hi = HDR_MARK_NOM;
		end else if (k == 1) begin
			nom_lo = HDR_SPACE_NOM;
			nom_hi = HDR_SPACE_NOM;
		end else if (want_mark) begin
			nom_lo = BIT_MARK_NOM;
			nom_hi = BIT_MARK_NOM;
		end else begin
			// bit space must miss both the zero and the one window
			nom_lo = BIT_MARK_NOM;
			nom_hi = ONE_SPACE_NOM;
		end
		if ($urandom_range(0, 1) == 1)
			send_pulse(!want_mark, pulse_len(nom_lo, nom_lo, 1'b1), k == 0);
		else
			send_pulse(want_mark, pulse_len(nom_lo, nom_hi, 1'b0), k == 0);
	endtask

	// Frame content: known frames, state words, near misses and plain noise.
	function automatic logic [FRAME_BITS-1:0] pick_frame();
		logic [WORD_W-1:0] w;
		logic [FRAME_BITS-1:0] f;
		int sel;
		sel = $urandom_range(0, 11);
		case (sel)
			0, 1: w = OFF_WORD;
			2, 3: w = TOGGLE_WORDS[$urandom_range(0, TOGGLE_CNT - 1)];
			4, 5, 6: w = {STATE_PREFIX, 8'($urandom), 8'($urandom)};
			7: w = {STATE_PREFIX, 8'($urandom), FAN_ONLY_NIBBLE, MBITS_FAN, 2'($urandom)};
			default: w = 24'($urandom);
		endcase
		f = {w[23:16], ~w[23:16], w[15:8], ~w[15:8], w[7:0], ~w[7:0]};
		if (sel == 8)
			f = ($urandom_range(0, 1) == 1) ? ECO_ON_FRAME : ECO_OFF_FRAME;
		else if (sel == 9)
			f = FRAME_BITS'({$urandom, $urandom});
		else if (sel == 10)
			// one bit off in a complement byte
			f = f ^ (48'd1 << (16 * $urandom_range(0, 2) + $urandom_range(0, 7)));
		return f;
	endfunction

	task automatic run_capture();
		logic [FRAME_BITS-1:0] f;
		int c;
		int k;
		f = pick_frame();
		c = $urandom_range(0, 9);
		n_captures++;
		if (c < 6) begin
			send_frame(f, PULSES_PER_FRAME);
			n_frames++;
			// trailing mark and repeat pulses land after the decision
			if ($urandom_range(0, 1) == 1) begin
				send_pulse(1'b1, pulse_len(BIT_MARK_NOM, BIT_MARK_NOM, 1'b1), 1'b0);
				repeat ($urandom_range(0, 6))
					send_pulse(1'($urandom), 16'($urandom), 1'b0);
			end
		end else if (c < 8) begin
			k = $urandom_range(0, PULSES_PER_FRAME - 1);
			send_frame(f, k);
			send_bad(k);
		end else if (c == 8) begin
			// truncated: the next capture start abandons it
			send_frame(f, $urandom_range(1, PULSES_PER_FRAME - 1));
		end else begin
			repeat ($urandom_range(1, 8))
				send_pulse(1'($urandom), 16'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic run_phase();
		int items0, frames0;
		items0 = n_items;
		frames0 = n_frames;
		while (n_items - items0 < PHASE_ITEMS || n_frames - frames0 < PHASE_FRAMES)
			run_capture();
	endtask

	// Stop sending and wait until every predicted decision has come out,
	// then give a truncated capture's last pulse time to settle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_tolerance(input int unsigned pct);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= TOL_W'(pct);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		tol_now = pct;
		n_settings++;
	endtask

	// Sink: holds one stall pattern for a while, then switches.
	initial begin
		int hold_left;
		int rmode;
		int rcnt;
		hold_left = 0;
		rmode = 0;
		rcnt = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0) begin
				rmode = $urandom_range(0, 3);
				hold_left = $urandom_range(20, 200);
			end
			hold_left--;
			rcnt++;
			case (rmode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= (rcnt % 9) < 2;
			endcase
		end
	end

	// Watchdog
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d decisions still due", cycles, pending);
		$display("FAILURE");
		$finish;
	end

	initial begin
		int unsigned plan [6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		tol_now = 32'(TOL_RESET);
		burst_left = 0;
		n_items = 0;
		n_captures = 0;
		n_frames = 0;
		n_settings = 1;
		// extremes first, then a random middle value and 100, back to the default last
		plan[0] = 0;
		plan[1] = 99;
		plan[2] = 127;
		plan[3] = $urandom_range(1, 98);
		plan[4] = 100;
		plan[5] = 32'(TOL_RESET);
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// directed pulses at the reset tolerance
		for (int i = 0; i < 24; i++)
			send_pulse(OPENING[i][17], OPENING[i][16:1], OPENING[i][0]);
		run_phase();

		foreach (plan[i]) begin
			write_tolerance(plan[i]);
			run_phase();
		end

		drain();
		$display("%0d pulses in %0d captures (%0d complete frames) over %0d tolerance settings;",
			n_items, n_captures, n_frames, n_settings);
		$display("%0d decisions checked", checked);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
